FILE: sv/ple_pkg.sv
// shared types, codes and defaults for the positional list engine
package ple_pkg;

  localparam int PLE_DEPTH   = 32;
  localparam int PLE_ACT_W   = 3;
  localparam int PLE_VAL_W   = 32;
  localparam int PLE_POS_W   = 6;
  localparam int PLE_STAT_W  = 2;
  localparam int PLE_CNT_W   = 6;

  localparam logic [PLE_ACT_W-1:0] ACT_INS_FRONT = 3'd0;
  localparam logic [PLE_ACT_W-1:0] ACT_INS_BACK  = 3'd1;
  localparam logic [PLE_ACT_W-1:0] ACT_INS_AT    = 3'd2;
  localparam logic [PLE_ACT_W-1:0] ACT_DEL_FRONT = 3'd3;
  localparam logic [PLE_ACT_W-1:0] ACT_DEL_BACK  = 3'd4;
  localparam logic [PLE_ACT_W-1:0] ACT_DEL_AT    = 3'd5;
  localparam logic [PLE_ACT_W-1:0] ACT_DUMP      = 3'd6;

  localparam logic [PLE_STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [PLE_STAT_W-1:0] STAT_BADPOS = 2'd1;
  localparam logic [PLE_STAT_W-1:0] STAT_FULL   = 2'd2;
  localparam logic [PLE_STAT_W-1:0] STAT_EMPTY  = 2'd3;

  typedef struct packed {
    logic [PLE_ACT_W-1:0]        action;
    logic signed [PLE_VAL_W-1:0] value;
    logic [PLE_POS_W-1:0]        position;
  } ple_in_t;

  typedef struct packed {
    logic [PLE_STAT_W-1:0]       status;
    logic [PLE_CNT_W-1:0]        count;
    logic signed [PLE_VAL_W-1:0] item_value;
    logic                        item_valid;
    logic                        last_of_run;
  } ple_out_t;

endpackage

FILE: sv/ple_store.sv
// entry memory: one write port, one registered read port
module ple_store #(
  parameter int DEPTH = ple_pkg::PLE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rd_en,
  input  logic [$clog2(DEPTH)-1:0]            rd_addr,
  output logic signed [ple_pkg::PLE_VAL_W-1:0] rd_data,
  input  logic                                wr_en,
  input  logic [$clog2(DEPTH)-1:0]            wr_addr,
  input  logic signed [ple_pkg::PLE_VAL_W-1:0] wr_data
);

  logic signed [ple_pkg::PLE_VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/ple_ctrl.sv
// sequencer: decodes a transaction, steps the shared cursor unit, builds results
module ple_ctrl #(
  parameter int DEPTH = ple_pkg::PLE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  ple_pkg::ple_in_t                     in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output ple_pkg::ple_out_t                    out_data,
  output logic                                 mem_rd_en,
  output logic [$clog2(DEPTH)-1:0]             mem_rd_addr,
  input  logic signed [ple_pkg::PLE_VAL_W-1:0] mem_rd_data,
  output logic                                 mem_wr_en,
  output logic [$clog2(DEPTH)-1:0]             mem_wr_addr,
  output logic signed [ple_pkg::PLE_VAL_W-1:0] mem_wr_data
);

  localparam int AW      = $clog2(DEPTH);
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int PW      = ple_pkg::PLE_POS_W;
  localparam int XW      = ((CW > PW) ? CW : PW) + 1;
  localparam int CntOutW = ple_pkg::PLE_CNT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_MOVE,
    ST_RESP,
    ST_DUMP_RD,
    ST_DUMP_OUT
  } state_t;

  state_t                               state_r, state_nxt;
  logic [CW-1:0]                        cnt_r, cnt_nxt;
  logic [CW-1:0]                        cur_r, cur_nxt;
  logic [CW-1:0]                        lim_r, lim_nxt;
  logic                                 ins_r, ins_nxt;
  logic signed [ple_pkg::PLE_VAL_W-1:0] val_r, val_nxt;
  logic [ple_pkg::PLE_STAT_W-1:0]       stat_r, stat_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  ple_pkg::ple_out_t                    out_data_r, out_data_nxt;

  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic [CW-1:0] pos_idx;
  logic [CW-1:0] cnt_dec;
  logic [CW-1:0] cur_inc;
  logic [CW-1:0] cur_step;
  logic          bad_ins;
  logic          bad_del;
  logic          is_full;
  logic          is_empty;
  logic          slot_free;
  logic          dump_last;

  // shared cursor unit
  assign cur_inc  = cur_r + CW'(1);
  assign cur_step = ins_r ? (cur_r - CW'(1)) : cur_inc;

  assign pos_x    = XW'(in_data.position);
  assign cnt_x    = XW'(cnt_r);
  assign pos_idx  = CW'(pos_x - XW'(1));
  assign cnt_dec  = cnt_r - CW'(1);
  assign bad_ins  = (pos_x == '0) || (pos_x > (cnt_x + XW'(1)));
  assign bad_del  = (pos_x == '0) || (pos_x > cnt_x);
  assign is_full  = (cnt_r == CW'(DEPTH));
  assign is_empty = (cnt_r == '0);
  assign slot_free = !out_valid_r || out_ready;
  assign dump_last = (cur_inc == cnt_r);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cur_nxt       = cur_r;
    lim_nxt       = lim_r;
    ins_nxt       = ins_r;
    val_nxt       = val_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = cur_r[AW-1:0];
    mem_wr_en     = 1'b0;
    mem_wr_addr   = cur_r[AW-1:0];
    mem_wr_data   = mem_rd_data;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          val_nxt   = in_data.value;
          stat_nxt  = ple_pkg::STAT_OK;
          state_nxt = ST_RESP;
          case (in_data.action)
            ple_pkg::ACT_INS_FRONT, ple_pkg::ACT_INS_BACK, ple_pkg::ACT_INS_AT: begin
              if (is_full) begin
                stat_nxt = ple_pkg::STAT_FULL;
              end else if ((in_data.action == ple_pkg::ACT_INS_AT) && bad_ins) begin
                stat_nxt = ple_pkg::STAT_BADPOS;
              end else begin
                ins_nxt   = 1'b1;
                cur_nxt   = cnt_r;
                state_nxt = ST_SHIFT;
                if (in_data.action == ple_pkg::ACT_INS_FRONT) begin
                  lim_nxt = '0;
                end else if (in_data.action == ple_pkg::ACT_INS_BACK) begin
                  lim_nxt = cnt_r;
                end else begin
                  lim_nxt = pos_idx;
                end
              end
            end
            ple_pkg::ACT_DEL_FRONT, ple_pkg::ACT_DEL_BACK, ple_pkg::ACT_DEL_AT: begin
              if (is_empty) begin
                stat_nxt = ple_pkg::STAT_EMPTY;
              end else if ((in_data.action == ple_pkg::ACT_DEL_AT) && bad_del) begin
                stat_nxt = ple_pkg::STAT_BADPOS;
              end else begin
                ins_nxt   = 1'b0;
                lim_nxt   = cnt_dec;
                state_nxt = ST_SHIFT;
                if (in_data.action == ple_pkg::ACT_DEL_FRONT) begin
                  cur_nxt = '0;
                end else if (in_data.action == ple_pkg::ACT_DEL_BACK) begin
                  cur_nxt = cnt_dec;
                end else begin
                  cur_nxt = pos_idx;
                end
              end
            end
            ple_pkg::ACT_DUMP: begin
              if (is_empty) begin
                stat_nxt = ple_pkg::STAT_EMPTY;
              end else begin
                cur_nxt   = '0;
                state_nxt = ST_DUMP_RD;
              end
            end
            default: begin
              stat_nxt = ple_pkg::STAT_OK;
            end
          endcase
        end
      end
      ST_SHIFT: begin
        if (cur_r == lim_r) begin
          if (ins_r) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = lim_r[AW-1:0];
            mem_wr_data = val_r;
            cnt_nxt     = cnt_r + CW'(1);
          end else begin
            cnt_nxt = cnt_dec;
          end
          state_nxt = ST_RESP;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = cur_step[AW-1:0];
          state_nxt   = ST_MOVE;
        end
      end
      ST_MOVE: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = cur_r[AW-1:0];
        mem_wr_data = mem_rd_data;
        cur_nxt     = cur_step;
        state_nxt   = ST_SHIFT;
      end
      ST_RESP: begin
        if (slot_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = stat_r;
          out_data_nxt.count       = CntOutW'(cnt_r);
          out_data_nxt.item_value  = '0;
          out_data_nxt.item_valid  = 1'b0;
          out_data_nxt.last_of_run = 1'b1;
          state_nxt                = ST_IDLE;
        end
      end
      ST_DUMP_RD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = cur_r[AW-1:0];
        state_nxt   = ST_DUMP_OUT;
      end
      ST_DUMP_OUT: begin
        if (slot_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = ple_pkg::STAT_OK;
          out_data_nxt.count       = CntOutW'(cnt_r);
          out_data_nxt.item_value  = mem_rd_data;
          out_data_nxt.item_valid  = 1'b1;
          out_data_nxt.last_of_run = dump_last;
          if (dump_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cur_nxt   = cur_inc;
            state_nxt = ST_DUMP_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r      <= cur_nxt;
    lim_r      <= lim_nxt;
    ins_r      <= ins_nxt;
    val_r      <= val_nxt;
    stat_r     <= stat_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_wr_in_shift: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> ((state_r == ST_SHIFT) || (state_r == ST_MOVE)))
    else $error("memory written outside a shift");

  a_cur_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SHIFT) || (state_r == ST_MOVE)) |-> (cur_r <= cnt_r))
    else $error("cursor beyond list");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready held across a transaction");

  a_dump_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DUMP_OUT) |-> (cur_r < cnt_r))
    else $error("dump cursor beyond list");

endmodule

FILE: sv/positional_list_engine.sv
// positional list engine: ordered list of signed entries with positional insert and delete
// insert or delete: each moved entry is read in ST_SHIFT and written in ST_MOVE, then ST_RESP registers out_valid
// refused or unused operations go from ST_IDLE straight to ST_RESP, which registers out_valid
// one transaction at a time: in_ready is high only in ST_IDLE, so the next accept waits until the result is registered
// dump: entries are read in ST_DUMP_RD and sent in ST_DUMP_OUT in list order, last entry flagged
// reset (rst_n, synchronous): list emptied, no result pending; memory contents are not cleared
module positional_list_engine #(
  parameter int DEPTH = ple_pkg::PLE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ple_pkg::ple_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ple_pkg::ple_out_t out_data
);

  localparam int AW = $clog2(DEPTH);

  logic                                 rd_en;
  logic [AW-1:0]                        rd_addr;
  logic signed [ple_pkg::PLE_VAL_W-1:0] rd_data;
  logic                                 wr_en;
  logic [AW-1:0]                        wr_addr;
  logic signed [ple_pkg::PLE_VAL_W-1:0] wr_data;

  ple_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .mem_rd_en  (rd_en),
    .mem_rd_addr(rd_addr),
    .mem_rd_data(rd_data),
    .mem_wr_en  (wr_en),
    .mem_wr_addr(wr_addr),
    .mem_wr_data(wr_data)
  );

  ple_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

endmodule

FILE: test/positional_list_engine_tb.sv
// testbench for the positional list engine: directed and random list operations checked in order
`timescale 1ns / 1ps

module positional_list_engine_tb;

  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 80;
  localparam int PHASE_ITEMS = 110;
  localparam int CNT_W       = ple_pkg::PLE_CNT_W;
  localparam int POS_W       = ple_pkg::PLE_POS_W;

  localparam logic [ple_pkg::PLE_ACT_W-1:0] ACT_UNUSED = 3'd7;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  ple_pkg::ple_in_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  ple_pkg::ple_out_t out_data;

  ple_pkg::ple_in_t     pending_ops[$];
  ple_pkg::ple_out_t    expected_results[$];
  logic signed [31:0]   list_vals[$];
  ple_pkg::ple_out_t    want;

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  gen_count = 0;
  bit  grow_mode = 1'b1;
  int  err_count = 0;
  int  ops_accepted = 0;
  int  results_checked = 0;
  int  dumps_seen = 0;
  int  full_rejects = 0;
  int  stall_cycles = 0;

  positional_list_engine u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // list length after an operation, used only to steer the stimulus
  function automatic int count_after(ple_pkg::ple_in_t op, int n);
    case (op.action)
      ple_pkg::ACT_INS_FRONT, ple_pkg::ACT_INS_BACK, ple_pkg::ACT_INS_AT: begin
        if (n < ple_pkg::PLE_DEPTH && (op.action != ple_pkg::ACT_INS_AT ||
            (op.position >= 1 && op.position <= n + 1)))
          return n + 1;
      end
      ple_pkg::ACT_DEL_FRONT, ple_pkg::ACT_DEL_BACK, ple_pkg::ACT_DEL_AT: begin
        if (n > 0 && (op.action != ple_pkg::ACT_DEL_AT ||
            (op.position >= 1 && op.position <= n)))
          return n - 1;
      end
      default: ;
    endcase
    return n;
  endfunction

  task automatic add_op(logic [ple_pkg::PLE_ACT_W-1:0] act, logic signed [31:0] val,
                        logic [ple_pkg::PLE_POS_W-1:0] pos);
    ple_pkg::ple_in_t op;
    op.action   = act;
    op.value    = val;
    op.position = pos;
    pending_ops.push_back(op);
    gen_count = count_after(op, gen_count);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(15))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sh0;
      3: return -32'sh1;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_random_op();
    int r;
    int lim;
    logic [ple_pkg::PLE_ACT_W-1:0] act;
    logic [ple_pkg::PLE_POS_W-1:0] pos;
    if (gen_count == ple_pkg::PLE_DEPTH && $urandom_range(99) < 30)
      grow_mode = 1'b0;
    else if (gen_count == 0 && $urandom_range(99) < 30)
      grow_mode = 1'b1;
    else if ($urandom_range(99) < 3)
      grow_mode = !grow_mode;
    r = $urandom_range(99);
    if (grow_mode)
      act = (r < 28) ? ple_pkg::ACT_INS_FRONT : (r < 56) ? ple_pkg::ACT_INS_BACK :
            (r < 80) ? ple_pkg::ACT_INS_AT : (r < 84) ? ple_pkg::ACT_DEL_FRONT :
            (r < 88) ? ple_pkg::ACT_DEL_BACK : (r < 92) ? ple_pkg::ACT_DEL_AT :
            (r < 98) ? ple_pkg::ACT_DUMP : ACT_UNUSED;
    else
      act = (r < 4) ? ple_pkg::ACT_INS_FRONT : (r < 8) ? ple_pkg::ACT_INS_BACK :
            (r < 12) ? ple_pkg::ACT_INS_AT : (r < 38) ? ple_pkg::ACT_DEL_FRONT :
            (r < 64) ? ple_pkg::ACT_DEL_BACK : (r < 90) ? ple_pkg::ACT_DEL_AT :
            (r < 98) ? ple_pkg::ACT_DUMP : ACT_UNUSED;
    if (act == ple_pkg::ACT_INS_AT || act == ple_pkg::ACT_DEL_AT) begin
      lim = (act == ple_pkg::ACT_INS_AT) ? gen_count + 1 : gen_count;
      if (lim >= 1 && $urandom_range(99) < 85)
        pos = POS_W'($urandom_range(lim, 1));
      else if ($urandom_range(1) == 0)
        pos = '0;
      else
        pos = POS_W'($urandom_range(63, lim + 1));
    end else begin
      pos = POS_W'($urandom_range(63));
    end
    add_op(act, pick_value(), pos);
  endtask

  task automatic predict_list_op(ple_pkg::ple_in_t op);
    ple_pkg::ple_out_t res;
    logic [ple_pkg::PLE_STAT_W-1:0] st;
    int n;
    int p;
    st = ple_pkg::STAT_OK;
    n  = list_vals.size();
    p  = op.position;
    res = '0;
    case (op.action)
      ple_pkg::ACT_INS_FRONT, ple_pkg::ACT_INS_BACK, ple_pkg::ACT_INS_AT: begin
        if (n >= ple_pkg::PLE_DEPTH) begin
          st = ple_pkg::STAT_FULL;
          full_rejects++;
        end else if (op.action == ple_pkg::ACT_INS_FRONT) begin
          list_vals.push_front(op.value);
        end else if (op.action == ple_pkg::ACT_INS_BACK) begin
          list_vals.push_back(op.value);
        end else if (p == 0 || p > n + 1) begin
          st = ple_pkg::STAT_BADPOS;
        end else begin
          list_vals.insert(p - 1, op.value);
        end
      end
      ple_pkg::ACT_DEL_FRONT, ple_pkg::ACT_DEL_BACK, ple_pkg::ACT_DEL_AT: begin
        if (n == 0) begin
          st = ple_pkg::STAT_EMPTY;
        end else if (op.action == ple_pkg::ACT_DEL_FRONT) begin
          list_vals.delete(0);
        end else if (op.action == ple_pkg::ACT_DEL_BACK) begin
          list_vals.delete(n - 1);
        end else if (p == 0 || p > n) begin
          st = ple_pkg::STAT_BADPOS;
        end else begin
          list_vals.delete(p - 1);
        end
      end
      ple_pkg::ACT_DUMP: begin
        dumps_seen++;
        if (n == 0)
          st = ple_pkg::STAT_EMPTY;
      end
      default: ;
    endcase
    if (op.action == ple_pkg::ACT_DUMP && n > 0) begin
      for (int i = 0; i < n; i++) begin
        res.status      = ple_pkg::STAT_OK;
        res.count       = CNT_W'(n);
        res.item_value  = list_vals[i];
        res.item_valid  = 1'b1;
        res.last_of_run = (i == n - 1);
        expected_results.push_back(res);
      end
    end else begin
      res.status      = st;
      res.count       = CNT_W'(list_vals.size());
      res.last_of_run = 1'b1;
      expected_results.push_back(res);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        predict_list_op(in_data);
        ops_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_ops.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result status=%0d count=%0d value=%0d valid=%0b last=%0b",
                   $time, out_data.status, out_data.count, out_data.item_value,
                   out_data.item_valid, out_data.last_of_run);
          err_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status || out_data.count !== want.count ||
              out_data.item_value !== want.item_value ||
              out_data.item_valid !== want.item_valid ||
              out_data.last_of_run !== want.last_of_run) begin
            $display("%0t: mismatch expected status=%0d count=%0d value=%0d valid=%0b last=%0b",
                     $time, want.status, want.count, want.item_value,
                     want.item_valid, want.last_of_run);
            $display("%0t:          actual   status=%0d count=%0d value=%0d valid=%0b last=%0b",
                     $time, out_data.status, out_data.count, out_data.item_value,
                     out_data.item_valid, out_data.last_of_run);
            err_count++;
          end
          results_checked++;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles with work outstanding but no transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        stall_cycles <= 0;
      else if (pending_ops.size() > 0 || in_valid || expected_results.size() > 0)
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int send_pct[3];
    int recv_pct[3];
    send_pct = '{23, 70, 0};
    recv_pct = '{70, 23, 0};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = send_pct[ph];
      recv_idle_pct = recv_pct[ph];
      if (ph == 0) begin
        // empty list corner cases, empty takes precedence over position
        add_op(ple_pkg::ACT_DUMP,      32'sd11, 6'd5);
        add_op(ple_pkg::ACT_DEL_FRONT, 32'sd12, 6'd0);
        add_op(ple_pkg::ACT_DEL_BACK,  32'sd13, 6'd63);
        add_op(ple_pkg::ACT_DEL_AT,    32'sd14, 6'd0);
        add_op(ple_pkg::ACT_INS_AT,    32'sd15, 6'd0);
        add_op(ple_pkg::ACT_INS_AT,    32'sd16, 6'd2);
        add_op(ple_pkg::ACT_INS_AT,    32'sh8000_0000, 6'd1);
        add_op(ple_pkg::ACT_INS_BACK,  32'sh7fff_ffff, 6'd0);
        add_op(ple_pkg::ACT_INS_FRONT, 32'sd0, 6'd63);
        // append via insert at count+1, then a middle insert
        add_op(ple_pkg::ACT_INS_AT,    -32'sd1, 6'd4);
        add_op(ple_pkg::ACT_INS_AT,    32'sd5, 6'd2);
        add_op(ple_pkg::ACT_DUMP,      32'sd0, 6'd0);
        add_op(ple_pkg::ACT_DEL_AT,    32'sd0, 6'd0);
        add_op(ple_pkg::ACT_DEL_AT,    32'sd0, 6'd6);
        add_op(ple_pkg::ACT_DEL_AT,    32'sd0, 6'd3);
        add_op(ple_pkg::ACT_DEL_AT,    32'sd0, 6'd4);
        add_op(ple_pkg::ACT_DEL_FRONT, 32'sd0, 6'd0);
        add_op(ple_pkg::ACT_DEL_BACK,  32'sd0, 6'd0);
        add_op(ACT_UNUSED,             32'sh5a5a_a5a5, 6'd42);
        add_op(ple_pkg::ACT_DUMP,      32'sd0, 6'd0);
        add_op(ple_pkg::ACT_DEL_AT,    32'sd0, 6'd1);
        add_op(ple_pkg::ACT_DUMP,      32'sd0, 6'd0);
      end
      for (int k = 0; k < PHASE_ITEMS; k++)
        add_random_op();
      while (pending_ops.size() > 0)
        @(posedge clk);
    end

    while (in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d list operations (%0d dumps, %0d inserts refused on a full list)",
             ops_accepted, dumps_seen, full_rejects);
    $display("checked %0d results under three send/receive throttling mixes, %0d errors",
             results_checked, err_count);
    if (err_count == 0 && expected_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: positional_list_engine.f
sv/ple_pkg.sv
sv/ple_store.sv
sv/ple_ctrl.sv
sv/positional_list_engine.sv
test/positional_list_engine_tb.sv
